// File: src/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, muted during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, muted during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/php_pkg.sv
// ----------------------------------------------------------------------------
// php_pkg
// types, constants and lookup functions of the packet header layer parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package php_pkg;

	localparam int MaxPacketBytes = 16384;
	localparam int OffW = 14;

	// header being walked
	typedef enum logic [3:0] {
		PH_ETH    = 4'd0,
		PH_VLAN   = 4'd1,
		PH_MPLS   = 4'd2,
		PH_IPV4   = 4'd3,
		PH_IPV6   = 4'd4,
		PH_FRAG   = 4'd5,
		PH_FRAGNF = 4'd6,
		PH_EXT    = 4'd7,
		PH_TCP    = 4'd8,
		PH_UDP    = 4'd9,
		PH_ICMP   = 4'd10,
		PH_ICMP6  = 4'd11,
		PH_DONE   = 4'd12
	} phase_t;

	localparam logic [1:0] IP_NONE = 2'd0;
	localparam logic [1:0] IP_V4   = 2'd1;
	localparam logic [1:0] IP_V6   = 2'd2;

	localparam logic [2:0] L4_NONE  = 3'd0;
	localparam logic [2:0] L4_TCP   = 3'd1;
	localparam logic [2:0] L4_UDP   = 3'd2;
	localparam logic [2:0] L4_ICMP  = 3'd3;
	localparam logic [2:0] L4_ICMP6 = 3'd4;

	localparam logic [15:0] FRAG_OFF_MASK = 16'hfff8;
	localparam logic [3:0]  IHL_MIN       = 4'd5;

	// layers found so far, also the result item
	typedef struct packed {
		logic            eth_found;
		logic [OffW-1:0] eth_offset;
		logic [1:0]      ip_kind;
		logic [OffW-1:0] ip_offset;
		logic            frag_found;
		logic [OffW-1:0] frag_offset;
		logic [2:0]      l4_kind;
		logic [OffW-1:0] l4_offset;
	} layers_t;

	// fixed header length of each phase
	function automatic logic [5:0] hdr_size(input phase_t ph);
		logic [5:0] s;
		case (ph)
			PH_ETH:    s = 6'd14;
			PH_VLAN:   s = 6'd4;
			PH_MPLS:   s = 6'd5;
			PH_IPV4:   s = 6'd20;
			PH_IPV6:   s = 6'd40;
			PH_FRAG:   s = 6'd8;
			PH_FRAGNF: s = 6'd8;
			PH_EXT:    s = 6'd2;
			PH_TCP:    s = 6'd20;
			PH_UDP:    s = 6'd8;
			PH_ICMP:   s = 6'd8;
			PH_ICMP6:  s = 6'd8;
			default:   s = 6'd1;
		endcase
		return s;
	endfunction

	// transport protocol to phase, done when unknown
	function automatic phase_t go_l4(input logic [7:0] proto);
		phase_t p;
		case (proto)
			8'd6:    p = PH_TCP;
			8'd17:   p = PH_UDP;
			8'd1:    p = PH_ICMP;
			8'd58:   p = PH_ICMP6;
			default: p = PH_DONE;
		endcase
		return p;
	endfunction

	// ipv6 next header to phase
	function automatic phase_t go_v6(input logic [7:0] proto);
		phase_t p;
		case (proto)
			8'd44:   p = PH_FRAG;
			8'd0:    p = PH_EXT;
			8'd43:   p = PH_EXT;
			8'd60:   p = PH_EXT;
			8'd135:  p = PH_EXT;
			default: p = go_l4(proto);
		endcase
		return p;
	endfunction

	// ethertype to phase
	function automatic phase_t go_type(input logic [15:0] t);
		phase_t p;
		case (t)
			16'h8100: p = PH_VLAN;
			16'h88a8: p = PH_VLAN;
			16'h9100: p = PH_VLAN;
			16'h9200: p = PH_VLAN;
			16'h9300: p = PH_VLAN;
			16'h8847: p = PH_MPLS;
			16'h8848: p = PH_MPLS;
			16'h0800: p = PH_IPV4;
			16'h86dd: p = PH_IPV6;
			default:  p = PH_DONE;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// File: src/php_core.sv
// ----------------------------------------------------------------------------
// php_core
// per-packet walk state, advanced by one byte per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module php_core #(
	parameter int MAX_PACKET_BYTES = php_pkg::MaxPacketBytes
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	output php_pkg::layers_t      layers
);
	import php_pkg::*;

	localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int END_W = ((POS_W > 12) ? POS_W : 12) + 1;

	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [END_W-1:0]   start_q, start_d;
	logic [END_W-1:0]   end_q, end_d;
	logic [15:0]        ntype_q, ntype_d;
	logic [31:0]        shift_q, shift_d;
	logic               stop_q, stop_d;
	layers_t            found_q, found_d;

	logic [END_W-1:0]   pos_e;
	logic [END_W-1:0]   idx;
	phase_t             go_ph;
	logic [END_W-1:0]   go_start;
	logic               go;

	// next state for one byte
	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		start_d  = start_q;
		end_d    = end_q;
		ntype_d  = ntype_q;
		shift_d  = shift_q;
		stop_d   = stop_q;
		found_d  = found_q;
		pos_e    = END_W'(pos_q);
		idx      = pos_e - start_q;
		go       = 1'b0;
		go_ph    = PH_DONE;
		go_start = start_q;

		if (pos_q < POS_W'(MAX_PACKET_BYTES)) begin
			pos_d = pos_q + 1'b1;
			if (!stop_q && pos_e >= start_q && pos_e < end_q) begin
				shift_d = {shift_q[23:0], data_byte};
				if (phase_q == PH_IPV4 && idx == '0)
					ntype_d = {4'd0, data_byte[3:0], 8'd0};
				if (phase_q == PH_IPV4 && idx == END_W'(9))
					ntype_d = {ntype_q[15:8], data_byte};
				if (phase_q == PH_IPV6 && idx == END_W'(6))
					ntype_d = {8'd0, data_byte};
				if (phase_q == PH_FRAG && idx == END_W'(3)) begin
					ntype_d = shift_d[31:16];
					if ((shift_d[15:0] & FRAG_OFF_MASK) != '0)
						phase_d = PH_FRAGNF;
				end

				// header complete
				if (pos_e + 1'b1 == end_q) begin
					case (phase_d)
						PH_ETH: begin
							found_d.eth_found  = 1'b1;
							found_d.eth_offset = OffW'(start_q);
							go       = 1'b1;
							go_ph    = go_type(shift_d[15:0]);
							go_start = end_q;
						end
						PH_VLAN: begin
							go       = 1'b1;
							go_ph    = go_type(shift_d[15:0]);
							go_start = end_q;
						end
						PH_MPLS: begin
							go = 1'b1;
							go_start = pos_e;
							if (!shift_d[16]) begin
								go_ph = PH_MPLS;
							end else begin
								case (shift_d[7:4])
									4'd0: begin
										go_ph    = PH_ETH;
										go_start = pos_e + END_W'(4);
									end
									4'd4: begin
										go_ph   = PH_IPV4;
										ntype_d = {4'd0, data_byte[3:0], 8'd0};
									end
									4'd6:    go_ph = PH_IPV6;
									default: go_ph = PH_DONE;
								endcase
							end
						end
						PH_IPV4: begin
							found_d.ip_kind   = IP_V4;
							found_d.ip_offset = OffW'(start_q);
							go = 1'b1;
							if (ntype_d[11:8] < IHL_MIN) begin
								go_ph = PH_DONE;
							end else begin
								go_ph    = go_l4(ntype_d[7:0]);
								go_start = start_q + END_W'({ntype_d[11:8], 2'b00});
							end
						end
						PH_IPV6: begin
							found_d.ip_kind   = IP_V6;
							found_d.ip_offset = OffW'(start_q);
							go       = 1'b1;
							go_ph    = go_v6(ntype_d[7:0]);
							go_start = end_q;
						end
						PH_FRAG: begin
							found_d.frag_found  = 1'b1;
							found_d.frag_offset = OffW'(start_q);
							go       = 1'b1;
							go_ph    = go_v6(ntype_d[15:8]);
							go_start = start_q
								+ END_W'({({1'b0, ntype_d[7:0]} + 9'd1), 3'b000});
						end
						PH_FRAGNF: begin
							found_d.frag_found  = 1'b1;
							found_d.frag_offset = OffW'(start_q);
							go    = 1'b1;
							go_ph = PH_DONE;
						end
						PH_EXT: begin
							go       = 1'b1;
							go_ph    = go_v6(shift_d[15:8]);
							go_start = start_q
								+ END_W'({({1'b0, shift_d[7:0]} + 9'd1), 3'b000});
						end
						PH_TCP, PH_UDP, PH_ICMP, PH_ICMP6: begin
							found_d.l4_kind   = 3'(phase_d) - 3'(PH_TCP) + 3'd1;
							found_d.l4_offset = OffW'(start_q);
							go    = 1'b1;
							go_ph = PH_DONE;
						end
						default: begin
							go    = 1'b1;
							go_ph = PH_DONE;
						end
					endcase
				end
			end
		end

		// enter the next header or stop the walk
		if (go) begin
			phase_d = go_ph;
			if (go_ph == PH_DONE) begin
				stop_d = 1'b1;
			end else begin
				start_d = go_start;
				end_d   = go_start + END_W'(hdr_size(go_ph));
			end
		end

		layers = found_d;
	end

	// walk state, cleared after each packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ETH;
			pos_q   <= '0;
			start_q <= '0;
			end_q   <= END_W'(14);
			ntype_q <= '0;
			shift_q <= '0;
			stop_q  <= 1'b0;
			found_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				phase_q <= PH_ETH;
				pos_q   <= '0;
				start_q <= '0;
				end_q   <= END_W'(14);
				ntype_q <= '0;
				shift_q <= '0;
				stop_q  <= 1'b0;
				found_q <= '0;
			end else begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				start_q <= start_d;
				end_q   <= end_d;
				ntype_q <= ntype_d;
				shift_q <= shift_d;
				stop_q  <= stop_d;
				found_q <= found_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/packet_header_layer_parser.sv
// ----------------------------------------------------------------------------
// packet_header_layer_parser
// streaming ethernet / vlan / mpls / ip / transport header layer parser
// ----------------------------------------------------------------------------
// Takes one packet byte per item and accepts a new item every clock cycle.
// Each byte lands in an input register and is folded into the walk state by
// one pass of logic; on the byte flagged last the layer report then goes
// from the input register to an output register. The only stall is
// a last byte waiting while a previous report has not been taken.
`timescale 1ns / 1ps
`default_nettype none

module packet_header_layer_parser #(
	parameter int MAX_PACKET_BYTES = php_pkg::MaxPacketBytes
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       byte_valid,
	output logic                            byte_ready,
	input  wire logic [7:0]                 data_byte,
	input  wire logic                       last_byte,
	output logic                            result_valid,
	input  wire logic                       result_ready,
	output logic                            eth_found,
	output logic [php_pkg::OffW-1:0]        eth_offset,
	output logic [1:0]                      ip_kind,
	output logic [php_pkg::OffW-1:0]        ip_offset,
	output logic                            frag_found,
	output logic [php_pkg::OffW-1:0]        frag_offset,
	output logic [2:0]                      l4_kind,
	output logic [php_pkg::OffW-1:0]        l4_offset
);
	import php_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       out_free;
	logic       go_s1;
	logic       res_valid_q;
	layers_t    layers;
	layers_t    res_q;

	// handshake between stages
	assign out_free   = !res_valid_q || result_ready;
	assign go_s1      = valid_s1 && (!last_s1 || out_free);
	assign byte_ready = !valid_s1 || go_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	php_core #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (go_s1),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.layers    (layers)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			res_q <= layers;
		end
	end

	assign result_valid = res_valid_q;
	assign eth_found    = res_q.eth_found;
	assign eth_offset   = res_q.eth_offset;
	assign ip_kind      = res_q.ip_kind;
	assign ip_offset    = res_q.ip_offset;
	assign frag_found   = res_q.frag_found;
	assign frag_offset  = res_q.frag_offset;
	assign l4_kind      = res_q.l4_kind;
	assign l4_offset    = res_q.l4_offset;

endmodule

`default_nettype wire

// File: src/php_checker.sv
// ----------------------------------------------------------------------------
// php_checker
// port-level checks of the header layer parser, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module php_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic        eth_found,
	input wire logic [13:0] eth_offset,
	input wire logic [1:0]  ip_kind,
	input wire logic        frag_found,
	input wire logic [2:0]  l4_kind
);
	import php_pkg::*;

	// a stalled report holds
	`ASSERT_NEXT(a_res_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(eth_offset))

	// ip is only reached through an ethernet header
	`ASSERT_IMPL(a_ip_needs_eth, clk, arst_n, result_valid && !eth_found, ip_kind == IP_NONE)

	// transport is only reached through ip
	`ASSERT_IMPL(a_l4_needs_ip, clk, arst_n, result_valid && l4_kind != L4_NONE, ip_kind != IP_NONE)

	// a fragment header only follows ipv6
	`ASSERT_IMPL(a_frag_v6, clk, arst_n, result_valid && frag_found, ip_kind == IP_V6)

endmodule

bind packet_header_layer_parser php_checker u_php_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.eth_found    (eth_found),
	.eth_offset   (eth_offset),
	.ip_kind      (ip_kind),
	.frag_found   (frag_found),
	.l4_kind      (l4_kind)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the packet header layer parser
// ----------------------------------------------------------------------------
// Packets are built layer by layer (ethernet, vlan tags, mpls labels, ipv4 or
// ipv6 with extension headers, transport) with random content, plus noise and
// truncated packets, and fed one byte per item with random gaps. A bit-exact
// walker in the bench predicts the layer report of every packet, and each
// report taken from the block is compared with the oldest prediction.
`timescale 1ns / 1ps

module tb_top;
	import php_pkg::*;

	// offset limit of the bench instance, small so that saturation is reached quickly
	localparam int PacketLimit = 256;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             byte_valid = 1'b0;
	logic             byte_ready;
	logic [7:0]       data_byte = 8'd0;
	logic             last_byte = 1'b0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	logic             eth_found;
	logic [OffW-1:0]  eth_offset;
	logic [1:0]       ip_kind;
	logic [OffW-1:0]  ip_offset;
	logic             frag_found;
	logic [OffW-1:0]  frag_offset;
	logic [2:0]       l4_kind;
	logic [OffW-1:0]  l4_offset;

	packet_header_layer_parser #(
		.MAX_PACKET_BYTES(PacketLimit)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_ready(byte_ready),
		.data_byte(data_byte), .last_byte(last_byte),
		.result_valid(result_valid), .result_ready(result_ready),
		.eth_found(eth_found), .eth_offset(eth_offset),
		.ip_kind(ip_kind), .ip_offset(ip_offset),
		.frag_found(frag_found), .frag_offset(frag_offset),
		.l4_kind(l4_kind), .l4_offset(l4_offset)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------
	// layer walker: predicted state
	// ------------------------------------------------------------------
	phase_t       walk_phase;
	int unsigned  walk_pos;
	int unsigned  walk_end;
	int unsigned  walk_type;
	int unsigned  walk_shift;
	bit           walk_halted;
	layers_t      walk_found;
	layers_t      pending_reports[$];

	int unsigned  mismatch_count = 0;
	int unsigned  bytes_sent = 0;
	int unsigned  packets_sent = 0;
	int unsigned  reports_seen = 0;
	int unsigned  l4_seen = 0;
	int unsigned  frag_seen = 0;
	bit           quiet = 1'b0;
	int unsigned  hold_cycles = 0;

	logic [7:0]   frame[$];

	function automatic int unsigned header_len(phase_t p);
		case (p)
			PH_ETH:              return 14;
			PH_VLAN:             return 4;
			PH_MPLS:             return 5;
			PH_IPV4, PH_TCP:     return 20;
			PH_IPV6:             return 40;
			PH_EXT:              return 2;
			PH_FRAG, PH_FRAGNF, PH_UDP, PH_ICMP, PH_ICMP6: return 8;
			default:             return 1;
		endcase
	endfunction

	function automatic void walk_enter(phase_t p, int unsigned start);
		walk_phase = p;
		walk_end = start + header_len(p);
	endfunction

	function automatic void walk_stop();
		walk_halted = 1'b1;
		walk_phase = PH_DONE;
	endfunction

	function automatic void walk_transport(int unsigned proto, int unsigned start);
		case (proto)
			6:       walk_enter(PH_TCP, start);
			17:      walk_enter(PH_UDP, start);
			1:       walk_enter(PH_ICMP, start);
			58:      walk_enter(PH_ICMP6, start);
			default: walk_stop();
		endcase
	endfunction

	function automatic void walk_v6_next(int unsigned proto, int unsigned start);
		case (proto)
			44:             walk_enter(PH_FRAG, start);
			0, 43, 60, 135: walk_enter(PH_EXT, start);
			default:        walk_transport(proto, start);
		endcase
	endfunction

	function automatic void walk_ethertype(int unsigned t, int unsigned start);
		case (t)
			16'h8100, 16'h88a8, 16'h9100, 16'h9200, 16'h9300: walk_enter(PH_VLAN, start);
			16'h8847, 16'h8848: walk_enter(PH_MPLS, start);
			16'h0800:           walk_enter(PH_IPV4, start);
			16'h86dd:           walk_enter(PH_IPV6, start);
			default:            walk_stop();
		endcase
	endfunction

	function automatic void walk_clear();
		walk_phase = PH_ETH;
		walk_pos = 0;
		walk_end = 14;
		walk_type = 0;
		walk_shift = 0;
		walk_halted = 1'b0;
		walk_found = '0;
	endfunction

	// fold one byte at a given offset into the walk
	function automatic void walk_byte(int unsigned b, int unsigned pos);
		int unsigned start;
		int unsigned idx;
		int unsigned ihl;
		int unsigned nib;
		start = walk_end - header_len(walk_phase);
		if (walk_halted || pos < start || pos >= walk_end) return;
		idx = pos - start;
		walk_shift = (walk_shift << 8) | b;
		if (walk_phase == PH_IPV4 && idx == 0) walk_type = (b & 15) << 8;
		if (walk_phase == PH_IPV4 && idx == 9) walk_type = (walk_type & 'hf00) | b;
		if (walk_phase == PH_IPV6 && idx == 6) walk_type = b;
		if (walk_phase == PH_FRAG && idx == 3) begin
			walk_type = (walk_shift >> 16) & 'hffff;
			if ((walk_shift & 'hfff8) != 0) walk_phase = PH_FRAGNF;
		end
		if (pos + 1 != walk_end) return;
		case (walk_phase)
			PH_ETH: begin
				walk_found.eth_found = 1'b1;
				walk_found.eth_offset = start[OffW-1:0];
				walk_ethertype(walk_shift & 'hffff, walk_end);
			end
			PH_VLAN: walk_ethertype(walk_shift & 'hffff, walk_end);
			PH_MPLS: begin
				if (((walk_shift >> 16) & 1) == 0) begin
					walk_enter(PH_MPLS, pos);
				end else begin
					nib = (walk_shift >> 4) & 15;
					if (nib == 0) walk_enter(PH_ETH, pos + 4);
					else if (nib == 4) begin
						walk_enter(PH_IPV4, pos);
						walk_type = (b & 15) << 8;
					end else if (nib == 6) walk_enter(PH_IPV6, pos);
					else walk_stop();
				end
			end
			PH_IPV4: begin
				ihl = (walk_type >> 8) & 15;
				walk_found.ip_kind = IP_V4;
				walk_found.ip_offset = start[OffW-1:0];
				if (ihl < 5) walk_stop();
				else walk_transport(walk_type & 'hff, start + ihl * 4);
			end
			PH_IPV6: begin
				walk_found.ip_kind = IP_V6;
				walk_found.ip_offset = start[OffW-1:0];
				walk_v6_next(walk_type & 'hff, walk_end);
			end
			PH_FRAG: begin
				walk_found.frag_found = 1'b1;
				walk_found.frag_offset = start[OffW-1:0];
				walk_v6_next((walk_type >> 8) & 'hff, start + ((walk_type & 'hff) + 1) * 8);
			end
			PH_FRAGNF: begin
				walk_found.frag_found = 1'b1;
				walk_found.frag_offset = start[OffW-1:0];
				walk_stop();
			end
			PH_EXT: walk_v6_next((walk_shift >> 8) & 'hff,
				start + ((walk_shift & 'hff) + 1) * 8);
			PH_TCP, PH_UDP, PH_ICMP, PH_ICMP6: begin
				case (walk_phase)
					PH_TCP:  walk_found.l4_kind = L4_TCP;
					PH_UDP:  walk_found.l4_kind = L4_UDP;
					PH_ICMP: walk_found.l4_kind = L4_ICMP;
					default: walk_found.l4_kind = L4_ICMP6;
				endcase
				walk_found.l4_offset = start[OffW-1:0];
				walk_stop();
			end
			default: walk_stop();
		endcase
	endfunction

	// predict on each accepted item
	function automatic void predict_item(logic [7:0] b, logic last);
		if (walk_pos < PacketLimit) begin
			walk_byte(b, walk_pos);
			walk_pos++;
		end
		if (last) begin
			pending_reports.push_back(walk_found);
			walk_clear();
		end
	endfunction

	// ------------------------------------------------------------------
	// report checker
	// ------------------------------------------------------------------
	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		layers_t w;
		if (arst_n && result_valid && result_ready) begin
			if (pending_reports.size() == 0) begin
				$error("report with none pending");
				mismatch_count++;
			end else begin
				w = pending_reports.pop_front();
				reports_seen++;
				if (w.l4_kind != L4_NONE) l4_seen++;
				if (w.frag_found) frag_seen++;
				check_field("eth_found", w.eth_found, eth_found);
				check_field("eth_offset", w.eth_offset, eth_offset);
				check_field("ip_kind", w.ip_kind, ip_kind);
				check_field("ip_offset", w.ip_offset, ip_offset);
				check_field("frag_found", w.frag_found, frag_found);
				check_field("frag_offset", w.frag_offset, frag_offset);
				check_field("l4_kind", w.l4_kind, l4_kind);
				check_field("l4_offset", w.l4_offset, l4_offset);
			end
		end
	end

	// ------------------------------------------------------------------
	// gaps, receiver and sender
	// ------------------------------------------------------------------
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: long hold when asked, else random short and long stalls
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				result_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
			end
		end
	end

	task automatic send_byte(logic [7:0] b, logic last);
		int unsigned g;
		g = pick_gap();
		if (g > 0) begin
			byte_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (!byte_ready);
		predict_item(b, last);
		bytes_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
		packets_sent++;
	endtask

	task automatic wait_idle();
		byte_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// packet building
	// ------------------------------------------------------------------
	function automatic void put(logic [7:0] b);
		frame.push_back(b);
	endfunction

	function automatic void put_rand(int unsigned n);
		repeat (n) frame.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void put_eth(logic [15:0] t);
		put_rand(12);
		put(t[15:8]);
		put(t[7:0]);
	endfunction

	function automatic void put_vlan(logic [15:0] t);
		put_rand(2);
		put(t[15:8]);
		put(t[7:0]);
	endfunction

	function automatic logic [15:0] pick_tpid();
		case ($urandom_range(0, 4))
			0:       return 16'h8100;
			1:       return 16'h88a8;
			2:       return 16'h9100;
			3:       return 16'h9200;
			default: return 16'h9300;
		endcase
	endfunction

	// four-byte label; bottom of stack in bit 0 of the third byte
	function automatic void put_label(bit bos);
		logic [7:0] b2;
		put_rand(2);
		b2 = 8'($urandom_range(0, 255));
		b2[0] = bos;
		put(b2);
		put_rand(1);
	endfunction

	function automatic void put_ipv4(logic [3:0] ihl, logic [7:0] proto);
		put({4'h4, ihl});
		put_rand(8);
		put(proto);
		put_rand(10);
		if (ihl > 5) put_rand((ihl - 5) * 4);
	endfunction

	function automatic void put_ipv6(logic [7:0] nh);
		put({4'h6, 4'($urandom_range(0, 15))});
		put_rand(5);
		put(nh);
		put_rand(33);
	endfunction

	function automatic void put_ext(logic [7:0] nh, logic [7:0] len);
		put(nh);
		put(len);
		put_rand((len + 1) * 8 - 2);
	endfunction

	function automatic void put_frag(logic [7:0] nh, logic [7:0] len, bit later);
		logic [15:0] off;
		off = 16'($urandom_range(0, 65535));
		if (later) begin
			if (off[15:3] == 0) off[3] = 1'b1;
		end else begin
			off[15:3] = '0;
		end
		put(nh);
		put(len);
		put(off[15:8]);
		put(off[7:0]);
		put_rand(4 + len * 8);
	endfunction

	function automatic void put_transport(logic [7:0] proto);
		case (proto)
			6:         put_rand(20);
			17, 1, 58: put_rand(8);
			default:   put_rand($urandom_range(0, 8));
		endcase
	endfunction

	function automatic logic [7:0] pick_proto();
		case ($urandom_range(0, 9))
			0, 1, 2: return 8'd6;
			3, 4, 5: return 8'd17;
			6:       return 8'd1;
			7:       return 8'd58;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void put_v4_stack();
		logic [3:0] ihl;
		logic [7:0] proto;
		ihl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(5, 7));
		proto = pick_proto();
		put_ipv4(ihl, proto);
		if (ihl >= 5) put_transport(proto);
	endfunction

	// ipv6 with a random chain of extension and fragment headers
	function automatic void put_v6_stack();
		logic [7:0] chain[5];
		int unsigned n;
		n = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 4))
				0:       chain[i] = 8'd0;
				1:       chain[i] = 8'd43;
				2:       chain[i] = 8'd60;
				3:       chain[i] = 8'd135;
				default: chain[i] = 8'd44;
			endcase
		end
		chain[n] = pick_proto();
		put_ipv6(chain[0]);
		for (int i = 0; i < n; i++) begin
			if (chain[i] == 8'd44) put_frag(chain[i + 1], 8'($urandom_range(0, 2)),
				$urandom_range(0, 3) == 0);
			else put_ext(chain[i + 1], 8'($urandom_range(0, 2)));
		end
		put_transport(chain[n]);
	endfunction

	function automatic void build_random_frame();
		int unsigned nv;
		int unsigned kind;
		logic [15:0] inner;
		logic [3:0] nib;
		frame.delete();
		if ($urandom_range(0, 9) == 0) begin
			put_rand($urandom_range(1, 60));
			return;
		end
		nv = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2, 3: inner = 16'h0800;
			4, 5, 6:    inner = 16'h86dd;
			7, 8:       inner = $urandom_range(0, 1) ? 16'h8847 : 16'h8848;
			default:    inner = 16'($urandom_range(0, 65535));
		endcase
		put_eth(nv > 0 ? pick_tpid() : inner);
		for (int i = 0; i < nv; i++) put_vlan(i == nv - 1 ? inner : pick_tpid());
		if (inner == 16'h0800) put_v4_stack();
		else if (inner == 16'h86dd) put_v6_stack();
		else if (inner == 16'h8847 || inner == 16'h8848) begin
			nv = $urandom_range(1, 3);
			for (int i = 0; i < nv; i++) put_label(i == nv - 1);
			case ($urandom_range(0, 3))
				0: begin
					put({4'h0, 4'($urandom_range(0, 15))});
					put_rand(3);
					put_eth(16'h0800);
					put_v4_stack();
				end
				1: put_v4_stack();
				2: put_v6_stack();
				default: begin
					do nib = 4'($urandom_range(0, 15)); while (nib == 0 || nib == 4 || nib == 6);
					put({nib, 4'($urandom_range(0, 15))});
					put_rand($urandom_range(0, 20));
				end
			endcase
		end
		put_rand($urandom_range(0, 8));
		// broken packets: cut anywhere
		if ($urandom_range(0, 6) == 0) begin
			nv = $urandom_range(1, frame.size());
			while (frame.size() > nv) void'(frame.pop_back());
		end
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed_layers();
		// single byte packet
		frame.delete(); put(8'hff); send_frame();
		// all zero, ethertype zero
		frame.delete(); repeat (30) put(8'h00); send_frame();
		// all ones
		frame.delete(); repeat (30) put(8'hff); send_frame();
		// qinq stack into ipv4 udp
		frame.delete(); put_eth(16'h88a8); put_vlan(16'h9100); put_vlan(16'h9200);
		put_vlan(16'h9300); put_vlan(16'h8100); put_vlan(16'h0800);
		put_ipv4(4'd5, 8'd17); put_transport(8'd17); send_frame();
		// mpls, control word, inner ethernet, ipv4 tcp with options
		frame.delete(); put_eth(16'h8847); put_label(0); put_label(1);
		put(8'h00); put_rand(3); put_eth(16'h0800); put_ipv4(4'd15, 8'd6);
		put_transport(8'd6); send_frame();
		// mpls into ipv6 icmpv6
		frame.delete(); put_eth(16'h8848); put_label(1); put_ipv6(8'd58);
		put_transport(8'd58); send_frame();
		// mpls with unknown nibble after bottom label
		frame.delete(); put_eth(16'h8847); put_label(1); put(8'h5a); put_rand(10);
		send_frame();
		// short ihl stops after ipv4
		frame.delete(); put_eth(16'h0800); put_ipv4(4'd4, 8'd6); put_rand(20); send_frame();
		frame.delete(); put_eth(16'h0800); put_ipv4(4'd0, 8'd17); put_rand(8); send_frame();
		// ipv4 icmp
		frame.delete(); put_eth(16'h0800); put_ipv4(4'd5, 8'd1); put_rand(8); send_frame();
		// ipv6 every extension kind then tcp
		frame.delete(); put_ipv6(8'd0); frame.delete();
		put_eth(16'h86dd); put_ipv6(8'd0); put_ext(8'd43, 8'd0); put_ext(8'd60, 8'd1);
		put_ext(8'd135, 8'd2); put_ext(8'd6, 8'd0); put_transport(8'd6); send_frame();
		// first fragment then udp
		frame.delete(); put_eth(16'h86dd); put_ipv6(8'd44); put_frag(8'd17, 8'd0, 0);
		put_transport(8'd17); send_frame();
		// non-first fragment stops the walk
		frame.delete(); put_eth(16'h86dd); put_ipv6(8'd44); put_frag(8'd6, 8'd0, 1);
		put_rand(20); send_frame();
		// unknown protocol and unknown ethertype
		frame.delete(); put_eth(16'h0800); put_ipv4(4'd5, 8'd99); put_rand(10); send_frame();
		frame.delete(); put_eth(16'h1234); put_rand(10); send_frame();
		// transport header one byte short
		frame.delete(); put_eth(16'h0800); put_ipv4(4'd5, 8'd6); put_rand(19); send_frame();
		// mpls label one byte short of its lookahead
		frame.delete(); put_eth(16'h8847); put_label(1); send_frame();
		wait_idle();
	endtask

	// packet longer than the offset limit, sent without gaps
	task automatic test_long_packet();
		quiet = 1'b1;
		frame.delete(); put_eth(16'h86dd); put_ipv6(8'd17); put_transport(8'd17);
		put_rand(PacketLimit + 40 - frame.size()); send_frame();
		// headers straddling the limit
		frame.delete(); put_rand(PacketLimit - 10); put_eth(16'h0800); put_ipv4(4'd5, 8'd6);
		send_frame();
		quiet = 1'b0;
		wait_idle();
	endtask

	// receiver holds off while short packets pile up
	task automatic test_backpressure();
		hold_cycles = 300;
		repeat (24) begin
			frame.delete();
			put_rand($urandom_range(1, 3));
			send_frame();
		end
		frame.delete(); put_eth(16'h0800); put_v4_stack(); send_frame();
		wait_idle();
	endtask

	task automatic test_random_packets();
		int unsigned start_bytes;
		int unsigned start_pkts;
		start_bytes = bytes_sent;
		start_pkts = packets_sent;
		while (bytes_sent - start_bytes < 600 || packets_sent - start_pkts < 8) begin
			build_random_frame();
			// a stretch of packets with no idling
			quiet = ($urandom_range(0, 7) == 0);
			send_frame();
		end
		quiet = 1'b0;
		wait_idle();
	endtask

	initial begin
		walk_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_layers();
		test_long_packet();
		test_backpressure();
		test_random_packets();
		repeat (20) @(posedge clk);
		$display("sent %0d packets in %0d bytes, checked %0d reports", packets_sent,
			bytes_sent, reports_seen);
		$display("reports with transport: %0d, with fragment: %0d", l4_seen, frag_seen);
		if (mismatch_count == 0 && pending_reports.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/php_pkg.sv
src/php_core.sv
src/packet_header_layer_parser.sv
src/php_checker.sv
tb/sv/tb_top.sv
